// ===== src/mpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared widths, register indexes, reset values and types of the Mandelbrot
// pixel colorer.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int PIX_BITS       = 12;
    localparam int SIZE_BITS      = 13;
    localparam int ITER_BITS      = 12;
    localparam int CFG_BITS       = 32;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;

    localparam int SPAN_BITS      = CFG_BITS + 1;
    localparam int DIV_NUM_BITS   = PIX_BITS + SPAN_BITS;
    localparam int DIV_DEN_BITS   = SIZE_BITS;

    localparam int FRAC_BITS_DEF  = 24;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_COORD_MIN     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COORD_MAX     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITER      = 3'd4;

    localparam logic [CFG_BITS-1:0]  COORD_MIN_RST = 32'hFF00_0000;
    localparam logic [CFG_BITS-1:0]  COORD_MAX_RST = 32'h0200_0000;
    localparam logic [SIZE_BITS-1:0] SIZE_RST      = 13'd2560;
    localparam logic [ITER_BITS-1:0] MAX_ITER_RST  = 12'd200;

    // one stage of the restoring divider chain
    typedef struct packed {
        logic                    valid;
        logic [DIV_DEN_BITS-1:0] rem;
        logic [DIV_NUM_BITS-1:0] acc;
        logic [DIV_DEN_BITS-1:0] den;
    } div_stage_t;

    typedef struct packed {
        logic                 done;
        logic [ITER_BITS-1:0] count;
    } esc_status_t;

endpackage

// ===== src/mpc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_div_cell
// One cell of the divider chain: resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpc_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mpc_pkg::div_stage_t stage_in,
    output mpc_pkg::div_stage_t stage_out
);
    import mpc_pkg::*;

    logic [DIV_DEN_BITS:0]   trial;
    logic [DIV_DEN_BITS:0]   diff;
    logic                    qbit;
    div_stage_t              stage_next;
    div_stage_t              stage_reg;

    always_comb
    begin
        trial = {stage_in.rem, stage_in.acc[DIV_NUM_BITS-1]};
        diff  = trial - {1'b0, stage_in.den};
        qbit  = (trial >= {1'b0, stage_in.den});
        stage_next       = stage_in;
        stage_next.rem   = qbit ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
        stage_next.acc   = {stage_in.acc[DIV_NUM_BITS-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== src/mpc_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_div_chain
// Row of divider cells, one quotient bit per cell, a new operation per cycle.
// ----------------------------------------------------------------------------
module mpc_div_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  mpc_pkg::div_stage_t req,
    output mpc_pkg::div_stage_t res
);
    import mpc_pkg::*;

    div_stage_t stages [DIV_NUM_BITS+1];

    assign stages[0] = req;

    for (genvar i = 0; i < DIV_NUM_BITS; i++)
    begin : g_cell
        mpc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage_in (stages[i]),
            .stage_out(stages[i+1])
        );
    end

    assign res = stages[DIV_NUM_BITS];

endmodule

// ===== src/mpc_escape_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_escape_core
// Escape-time iteration z = z^2 + c: each iteration forms the products, then adds and tests for escape.
// ----------------------------------------------------------------------------
module mpc_escape_core #(
    parameter int FRAC_BITS  = mpc_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [COORD_BITS-1:0]     x0,
    input  logic signed [COORD_BITS-1:0]     y0,
    input  logic [mpc_pkg::ITER_BITS-1:0]    limit,
    output mpc_pkg::esc_status_t             status
);
    import mpc_pkg::*;

    localparam int XW = ((COORD_BITS > FRAC_BITS + 7) ? COORD_BITS : FRAC_BITS + 7) + 1;
    localparam int CW = FRAC_BITS + 4;
    localparam int SW = FRAC_BITS + 5;
    localparam int XYW = FRAC_BITS + 7;

    localparam logic signed [XW-1:0] FOUR_X =
        {{(XW-FRAC_BITS-3){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};
    localparam logic signed [XW-1:0] NEG_FOUR_X = -FOUR_X;
    localparam logic signed [CW-1:0] FOUR_C = {2'b01, {(FRAC_BITS+2){1'b0}}};
    localparam logic signed [CW-1:0] NEG_FOUR_C = -FOUR_C;
    localparam logic [SW:0] FOUR_SQ = {3'b000, 1'b1, {(FRAC_BITS+2){1'b0}}};

    typedef enum logic [1:0] {ESC_IDLE, ESC_MUL, ESC_TEST} esc_state_t;

    esc_state_t              state_reg;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic [SW-1:0]           x2_reg;
    logic [SW-1:0]           y2_reg;
    logic signed [XYW-1:0]   xy_reg;
    logic [ITER_BITS-1:0]    it_reg;
    logic                    done_reg;

    logic signed [CW-1:0]    xc;
    logic signed [CW-1:0]    yc;
    logic [CW-1:0]           axw;
    logic [CW-1:0]           ayw;
    logic [CW-2:0]           ax;
    logic [CW-2:0]           ay;
    logic [2*CW-3:0]         sqx;
    logic [2*CW-3:0]         sqy;
    logic signed [2*CW-1:0]  prod;
    logic [SW:0]             mag_sum;
    logic signed [XW-1:0]    x_next;
    logic signed [XW-1:0]    y_next;

    always_comb
    begin
        if (x_reg > FOUR_X)
            xc = FOUR_C;
        else if (x_reg < NEG_FOUR_X)
            xc = NEG_FOUR_C;
        else
            xc = CW'(x_reg);
        if (y_reg > FOUR_X)
            yc = FOUR_C;
        else if (y_reg < NEG_FOUR_X)
            yc = NEG_FOUR_C;
        else
            yc = CW'(y_reg);
        axw  = xc[CW-1] ? -xc : xc;
        ayw  = yc[CW-1] ? -yc : yc;
        ax   = axw[CW-2:0];
        ay   = ayw[CW-2:0];
        sqx  = ax * ax;
        sqy  = ay * ay;
        prod = xc * yc;
        mag_sum = {1'b0, x2_reg} + {1'b0, y2_reg};
        x_next  = $signed({{(XW-SW){1'b0}}, x2_reg}) - $signed({{(XW-SW){1'b0}}, y2_reg})
                  + XW'(x0);
        y_next  = XW'(xy_reg) + XW'(y0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ESC_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            xy_reg    <= '0;
            it_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ESC_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        it_reg    <= '0;
                        state_reg <= ESC_MUL;
                    end
                end
                ESC_MUL:
                begin
                    x2_reg    <= sqx[FRAC_BITS +: SW];
                    y2_reg    <= sqy[FRAC_BITS +: SW];
                    // 2*x*y shifted by frac bits, floor rounding
                    xy_reg    <= prod[FRAC_BITS-1 +: XYW];
                    state_reg <= ESC_TEST;
                end
                ESC_TEST:
                begin
                    if (mag_sum > FOUR_SQ || it_reg >= limit)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ESC_IDLE;
                    end
                    else
                    begin
                        x_reg     <= x_next;
                        y_reg     <= y_next;
                        it_reg    <= it_reg + 1'b1;
                        state_reg <= ESC_MUL;
                    end
                end
                default:
                begin
                    state_reg <= ESC_IDLE;
                end
            endcase
        end
    end

    assign status.done  = done_reg;
    assign status.count = it_reg;

endmodule

// ===== src/mandelbrot_pixel_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_pixel_color
// Maps a pixel onto the complex window, runs the escape-time iteration and
// colors the pixel from the iteration count.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time. The iteration count reached is at most
// the iteration limit; when it equals the limit, the brightness division is
// skipped. The escape core forms the products, then adds and tests for
// escape, in each iteration; the two coordinate divisions and the brightness
// division each pass the 45-cell divider chain, the x and y divisions
// overlapping in it; the blue channel square root is found bit by bit from
// the top. A new pixel is taken as soon as the previous result sits in the
// output register.
module mandelbrot_pixel_color #(
    parameter int FRAC_BITS  = mpc_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mpc_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mpc_pkg::PIX_BITS-1:0]         pixel_x,
    input  logic [mpc_pkg::PIX_BITS-1:0]         pixel_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mpc_pkg::COLOR_BITS-1:0]       red,
    output logic [mpc_pkg::COLOR_BITS-1:0]       green,
    output logic [mpc_pkg::COLOR_BITS-1:0]       blue,
    output logic [mpc_pkg::ITER_BITS-1:0]        iterations
);
    import mpc_pkg::*;

    localparam int NW   = DIV_NUM_BITS;
    localparam int SUMW = NW + 2;
    localparam int EW   = (SUMW > COORD_BITS) ? SUMW : COORD_BITS;
    localparam logic signed [EW-1:0] SAT_HI =
        {{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - 1;

    typedef enum logic [3:0] {
        T_IDLE, T_MUL, T_DIVX, T_DIVY, T_WAITX, T_WAITY, T_START, T_ITER,
        T_BRIGHT, T_WAITB, T_SQRT, T_OUT
    } top_state_t;

    top_state_t                  state_reg;
    logic signed [CFG_BITS-1:0]  cfg_min_reg;
    logic signed [CFG_BITS-1:0]  cfg_max_reg;
    logic [SIZE_BITS-1:0]        cfg_width_reg;
    logic [SIZE_BITS-1:0]        cfg_height_reg;
    logic [ITER_BITS-1:0]        cfg_iter_reg;

    logic [PIX_BITS-1:0]         px_reg;
    logic [PIX_BITS-1:0]         py_reg;
    logic signed [SPAN_BITS-1:0] span_reg;
    logic signed [NW-1:0]        prodx_reg;
    logic signed [NW-1:0]        prody_reg;
    logic signed [COORD_BITS-1:0] x0_reg;
    logic signed [COORD_BITS-1:0] y0_reg;
    logic [ITER_BITS-1:0]        it_reg;
    logic [COLOR_BITS-1:0]       bright_reg;
    logic [15:0]                 sqv_reg;
    logic [COLOR_BITS-1:0]       root_reg;
    logic [COLOR_BITS-1:0]       bit_reg;

    logic                        out_valid_reg;
    logic [COLOR_BITS-1:0]       red_reg;
    logic [COLOR_BITS-1:0]       green_reg;
    logic [COLOR_BITS-1:0]       blue_reg;
    logic [ITER_BITS-1:0]        iter_out_reg;

    logic signed [NW:0]          prodx_full;
    logic signed [NW:0]          prody_full;
    logic [NW-1:0]               mag_x;
    logic [NW-1:0]               mag_y;
    logic [DIV_DEN_BITS-1:0]     den_x;
    logic [DIV_DEN_BITS-1:0]     den_y;
    logic [19:0]                 it255;
    logic                        bright_nz;
    div_stage_t                  div_req;
    div_stage_t                  div_res;
    esc_status_t                 esc_status;

    logic                        sel_neg;
    logic signed [SUMW-1:0]      q_ext;
    logic signed [SUMW-1:0]      map_sum;
    logic signed [EW-1:0]        map_ext;
    logic signed [COORD_BITS-1:0] map_c;

    logic [COLOR_BITS-1:0]       trial_root;
    logic [15:0]                 trial_sq;
    logic [15:0]                 bsq;
    logic [16:0]                 red_tmp;

    always_comb
    begin
        prodx_full = $signed({1'b0, px_reg}) * span_reg;
        prody_full = $signed({1'b0, py_reg}) * span_reg;
        mag_x      = prodx_reg[NW-1] ? NW'(-prodx_reg) : prodx_reg;
        mag_y      = prody_reg[NW-1] ? NW'(-prody_reg) : prody_reg;
        den_x      = (cfg_width_reg == '0) ? DIV_DEN_BITS'(1) : cfg_width_reg;
        den_y      = (cfg_height_reg == '0) ? DIV_DEN_BITS'(1) : cfg_height_reg;
        it255      = {it_reg, 8'b0} - {8'b0, it_reg};
        bright_nz  = (it_reg != cfg_iter_reg) && (cfg_iter_reg != '0);

        div_req = '0;
        case (state_reg)
            T_DIVX:
            begin
                div_req.valid = 1'b1;
                div_req.acc   = mag_x;
                div_req.den   = den_x;
            end
            T_DIVY:
            begin
                div_req.valid = 1'b1;
                div_req.acc   = mag_y;
                div_req.den   = den_y;
            end
            T_BRIGHT:
            begin
                div_req.valid = bright_nz;
                div_req.acc   = NW'(it255);
                div_req.den   = {1'b0, cfg_iter_reg};
            end
            default:
            begin
                div_req = '0;
            end
        endcase

        // floor division of a signed product: round magnitude away when negative
        sel_neg = (state_reg == T_WAITX) ? prodx_reg[NW-1] : prody_reg[NW-1];
        q_ext   = $signed({2'b00, div_res.acc});
        if (sel_neg)
            q_ext = -q_ext - $signed({{(SUMW-1){1'b0}}, (div_res.rem != '0)});
        map_sum = q_ext + SUMW'(cfg_min_reg);
        map_ext = EW'(map_sum);
        if (map_ext > SAT_HI)
            map_c = COORD_BITS'(SAT_HI);
        else if (map_ext < SAT_LO)
            map_c = COORD_BITS'(SAT_LO);
        else
            map_c = COORD_BITS'(map_ext);

        trial_root = root_reg | bit_reg;
        trial_sq   = trial_root * trial_root;
        bsq        = bright_reg * bright_reg;
        // divide by 255 for values below 65535
        red_tmp    = {1'b0, bsq} + 17'd1 + {9'b0, bsq[15:8]};
    end

    mpc_div_chain u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .res  (div_res)
    );

    mpc_escape_core #(
        .FRAC_BITS (FRAC_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_escape (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == T_START),
        .x0    (x0_reg),
        .y0    (y0_reg),
        .limit (cfg_iter_reg),
        .status(esc_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            cfg_min_reg    <= COORD_MIN_RST;
            cfg_max_reg    <= COORD_MAX_RST;
            cfg_width_reg  <= SIZE_RST;
            cfg_height_reg <= SIZE_RST;
            cfg_iter_reg   <= MAX_ITER_RST;
            out_valid_reg  <= 1'b0;
            px_reg         <= '0;
            py_reg         <= '0;
            span_reg       <= '0;
            prodx_reg      <= '0;
            prody_reg      <= '0;
            x0_reg         <= '0;
            y0_reg         <= '0;
            it_reg         <= '0;
            bright_reg     <= '0;
            sqv_reg        <= '0;
            root_reg       <= '0;
            bit_reg        <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            iter_out_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COORD_MIN:    cfg_min_reg    <= cfg_data;
                    REG_COORD_MAX:    cfg_max_reg    <= cfg_data;
                    REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data[SIZE_BITS-1:0];
                    REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data[SIZE_BITS-1:0];
                    REG_MAX_ITER:     cfg_iter_reg   <= cfg_data[ITER_BITS-1:0];
                    default:          ;
                endcase
            end

            // in T_OUT the output register is reloaded instead
            if (out_valid_reg && !out_stall && state_reg != T_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg    <= pixel_x;
                        py_reg    <= pixel_y;
                        span_reg  <= SPAN_BITS'(cfg_max_reg) - SPAN_BITS'(cfg_min_reg);
                        state_reg <= T_MUL;
                    end
                end
                T_MUL:
                begin
                    prodx_reg <= prodx_full[NW-1:0];
                    prody_reg <= prody_full[NW-1:0];
                    state_reg <= T_DIVX;
                end
                T_DIVX:
                begin
                    state_reg <= T_DIVY;
                end
                T_DIVY:
                begin
                    state_reg <= T_WAITX;
                end
                T_WAITX:
                begin
                    if (div_res.valid)
                    begin
                        x0_reg    <= map_c;
                        state_reg <= T_WAITY;
                    end
                end
                T_WAITY:
                begin
                    if (div_res.valid)
                    begin
                        y0_reg    <= map_c;
                        state_reg <= T_START;
                    end
                end
                T_START:
                begin
                    state_reg <= T_ITER;
                end
                T_ITER:
                begin
                    if (esc_status.done)
                    begin
                        it_reg    <= esc_status.count;
                        state_reg <= T_BRIGHT;
                    end
                end
                T_BRIGHT:
                begin
                    root_reg <= '0;
                    bit_reg  <= 8'h80;
                    if (bright_nz)
                    begin
                        state_reg <= T_WAITB;
                    end
                    else
                    begin
                        bright_reg <= '0;
                        sqv_reg    <= '0;
                        state_reg  <= T_SQRT;
                    end
                end
                T_WAITB:
                begin
                    if (div_res.valid)
                    begin
                        bright_reg <= div_res.acc[COLOR_BITS-1:0];
                        sqv_reg    <= {div_res.acc[COLOR_BITS-1:0], 8'b0}
                                      - {8'b0, div_res.acc[COLOR_BITS-1:0]};
                        state_reg  <= T_SQRT;
                    end
                end
                T_SQRT:
                begin
                    if (trial_sq <= sqv_reg)
                        root_reg <= trial_root;
                    bit_reg <= bit_reg >> 1;
                    if (bit_reg[0])
                        state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        red_reg       <= red_tmp[15:8];
                        green_reg     <= bright_reg;
                        blue_reg      <= root_reg;
                        iter_out_reg  <= it_reg;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != T_IDLE);
    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign iterations = iter_out_reg;

endmodule
